>>> hw/rtl/urm_pkg.sv
// shared types and constants for the ultrasonic range meter
package urm_pkg;

   // field widths
   localparam int TICK_W     = 32;
   localparam int MODE_W     = 2;
   localparam int INTERVAL_W = 24;
   localparam int TIMEOUT_W  = 16;
   localparam int MM_W       = 16;
   localparam int DIST_W     = 17;

   // stream and register port widths
   localparam int REQ_FIELD_W = 3 + MM_W;          // echo, presence, tof_present, tof_mm
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_FIELD_W = 2 + DIST_W;        // trigger, distance, updated
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = INTERVAL_W;

   // default trigger pulse shape
   localparam int TRIG_LOW_TICKS_DEF  = 2;
   localparam int TRIG_HIGH_TICKS_DEF = 10;

   // distance fraction bits; the scale constants below are worked out for this value
   localparam int FRAC_BITS = 4;
   localparam logic [DIST_W-1:0] FAR_Q = DIST_W'(999 << FRAC_BITS);

   // echo: q = (w*1715*16 + 50000) / 100000 = (w*343 + 625) / 1250 for w up to 16 bits
   localparam int ECHO_NUM_W       = 25;
   localparam int ECHO_PROD_W      = 51;
   localparam int ECHO_Q_W         = 15;
   localparam int ECHO_RECIP_SHIFT = 36;
   localparam logic [ECHO_NUM_W-1:0] ECHO_MUL = ECHO_NUM_W'(343);
   localparam logic [ECHO_NUM_W-1:0] ECHO_ADD = ECHO_NUM_W'(625);
   // ceil(2^36 / 1250), exact for numerators below 2^25
   localparam logic [ECHO_PROD_W-1:0] ECHO_RECIP = ECHO_PROD_W'(54975582);

   // time of flight: q = (mm*16 + 5) / 10 = (mm*8 + 2) / 5
   localparam int TOF_NUM_W       = 20;
   localparam int TOF_PROD_W      = 41;
   localparam int TOF_RECIP_SHIFT = 23;
   localparam logic [TOF_NUM_W-1:0] TOF_ADD = TOF_NUM_W'(2);
   // ceil(2^23 / 5), exact for numerators below 2^20
   localparam logic [TOF_PROD_W-1:0] TOF_RECIP = TOF_PROD_W'(1677722);

   localparam logic [MM_W-1:0] TOF_OUT_OF_RANGE = '1;

   // range mode codes; any other code runs echo timing
   localparam logic [MODE_W-1:0] MODE_ECHO     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PRESENCE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TOF      = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_MODE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERVAL_US = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_US  = 2'd2;

   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(100000);
   localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET  = TIMEOUT_W'(30000);

   // what the held distance becomes for one item
   typedef enum logic [2:0] {
      SEL_KEEP,
      SEL_FAR,
      SEL_ZERO,
      SEL_ECHO,
      SEL_TOF
   } dist_sel_type;

   // control decision for one item, handed to the scaling pipeline
   typedef struct packed {
      logic               trig;
      logic               updated;
      dist_sel_type       sel;
      logic [TIMEOUT_W-1:0] echo_width;
      logic [MM_W-1:0]    tof_mm;
   } ctl_type;

   // stage loads for the scaling pipeline
   typedef struct packed {
      logic load_num;
      logic load_quo;
      logic load_held;
   } scale_en_type;

endpackage

>>> hw/rtl/ultrasonic_range_meter.sv
// ultrasonic range meter top level: config registers, stream stages and output register
// pipeline: a result reaches rsp through the control, numerator, quotient and output registers
//   that lie behind the input register
// throughput: one item per cycle while rsp is taken; every stage has its own valid
//   and fills bubbles, so req_tready drops only when all five stages hold items and rsp is stalled
// reset: synchronous, clears all stages, tick and echo state; held distance reads 999 cm,
//   range_mode 0, interval_us 100000, timeout_us 30000
module ultrasonic_range_meter import urm_pkg::*; #(
   parameter int TRIG_LOW_TICKS  = TRIG_LOW_TICKS_DEF,
   parameter int TRIG_HIGH_TICKS = TRIG_HIGH_TICKS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // register write port
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // input stream, one transfer per microsecond tick
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [0] echo_level, [1] presence_level, [2] tof_present, [18:3] tof_mm, rest zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // result stream, one transfer per tick
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [0] trigger_level, [17:1] distance_q4, [18] distance_updated, rest zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // configuration registers
   logic [MODE_W-1:0]     mode_ff;
   logic [INTERVAL_W-1:0] interval_ff;
   logic [TIMEOUT_W-1:0]  timeout_ff;

   // stage valids: input, control, numerator, quotient, output
   logic v0_ff, v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic adv1, adv2, adv3, adv_out;

   logic [REQ_FIELD_W-1:0] req_data_ff;
   logic [RSP_FIELD_W-1:0] rsp_data_ff, rsp_data_in;

   ctl_type      ctl;
   scale_en_type scale_en;
   logic              trigger_level;
   logic [DIST_W-1:0] distance_q4;
   logic              distance_updated;

   // a stage moves when it is empty or the one after it moves
   assign adv_out    = !rsp_valid_ff || rsp_tready;
   assign adv3       = !v3_ff || adv_out;
   assign adv2       = !v2_ff || adv3;
   assign adv1       = !v1_ff || adv2;
   assign req_tready = !v0_ff || adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_ECHO;
         interval_ff <= INTERVAL_RESET;
         timeout_ff  <= TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RANGE_MODE:  mode_ff     <= csr_wdata[MODE_W-1:0];
            CSR_INTERVAL_US: interval_ff <= csr_wdata[INTERVAL_W-1:0];
            CSR_TIMEOUT_US:  timeout_ff  <= csr_wdata[TIMEOUT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) v0_ff        <= req_tvalid;
         if (adv1)       v1_ff        <= v0_ff;
         if (adv2)       v2_ff        <= v1_ff;
         if (adv3)       v3_ff        <= v2_ff;
         if (adv_out)    rsp_valid_ff <= v3_ff;
      end
   end

   // input register, loaded on each req transfer
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_data_ff <= req_tdata[REQ_FIELD_W-1:0];
      end
   end

   // tick state advances once per item as it leaves the input register
   urm_ctrl #(
      .TRIG_LOW_TICKS  (TRIG_LOW_TICKS),
      .TRIG_HIGH_TICKS (TRIG_HIGH_TICKS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .step           (v0_ff && adv1),
      .load           (adv1),
      .echo_level     (req_data_ff[0]),
      .presence_level (req_data_ff[1]),
      .tof_present    (req_data_ff[2]),
      .tof_mm         (req_data_ff[3 +: MM_W]),
      .range_mode     (mode_ff),
      .interval_us    (interval_ff),
      .timeout_us     (timeout_ff),
      .ctl_out        (ctl)
   );

   assign scale_en.load_num  = adv2;
   assign scale_en.load_quo  = adv3;
   // held distance changes only when a real item goes to the output register
   assign scale_en.load_held = v3_ff && adv_out;

   urm_scale u_scale (
      .clock            (clock),
      .reset            (reset),
      .en               (scale_en),
      .ctl              (ctl),
      .trigger_level    (trigger_level),
      .distance_q4      (distance_q4),
      .distance_updated (distance_updated)
   );

   assign rsp_data_in = {distance_updated, distance_q4, trigger_level};

   // output register parts the result side from the pipeline
   always_ff @(posedge clock) begin
      if (adv_out && v3_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_FIELD_W){1'b0}}, rsp_data_ff};

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> v0_ff && v1_ff && v2_ff && v3_ff && rsp_valid_ff && !rsp_tready)
      else $error("input stalled with room in the pipeline");

endmodule

>>> hw/rtl/urm_ctrl.sv
// echo edge timing, trigger pulse sequencing and distance source selection
module urm_ctrl import urm_pkg::*; #(
   parameter int TRIG_LOW_TICKS  = TRIG_LOW_TICKS_DEF,
   parameter int TRIG_HIGH_TICKS = TRIG_HIGH_TICKS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  load,
   input  logic                  echo_level,
   input  logic                  presence_level,
   input  logic                  tof_present,
   input  logic [MM_W-1:0]       tof_mm,
   input  logic [MODE_W-1:0]     range_mode,
   input  logic [INTERVAL_W-1:0] interval_us,
   input  logic [TIMEOUT_W-1:0]  timeout_us,
   output ctl_type               ctl_out
);

   localparam int PHASE_W = $clog2(TRIG_LOW_TICKS + TRIG_HIGH_TICKS + 1);
   localparam logic [PHASE_W-1:0] PHASE_LAST  = PHASE_W'(TRIG_LOW_TICKS + TRIG_HIGH_TICKS);
   localparam logic [PHASE_W-1:0] PHASE_LOW   = PHASE_W'(TRIG_LOW_TICKS);
   localparam logic [PHASE_W-1:0] PHASE_FIRST = PHASE_W'(1);

   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [TICK_W-1:0]  start_ff, start_in;
   logic [TICK_W-1:0]  width_ff, width_in;
   logic               done_ff, done_in;
   logic               pending_ff, pending_in;
   logic               prev_ff, prev_in;
   logic [TICK_W-1:0]  last_trig_ff, last_trig_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   ctl_type            ctl_ff, ctl_in;
   logic               period_due;

   assign period_due = (tick_ff - last_trig_ff) >= TICK_W'(interval_us);

   always_comb begin
      tick_in      = tick_ff + TICK_W'(1);
      start_in     = start_ff;
      width_in     = width_ff;
      done_in      = done_ff;
      pending_in   = pending_ff;
      prev_in      = echo_level;
      last_trig_in = last_trig_ff;
      phase_in     = phase_ff;
      ctl_in.trig       = 1'b0;
      ctl_in.updated    = 1'b0;
      ctl_in.sel        = SEL_KEEP;
      ctl_in.echo_width = width_ff[TIMEOUT_W-1:0];
      ctl_in.tof_mm     = tof_mm;

      // echo edges are tracked in every mode
      if (echo_level && !prev_ff) begin
         start_in = tick_ff;
      end else if (!echo_level && prev_ff) begin
         width_in = tick_ff - start_ff;
         done_in  = 1'b1;
      end
      ctl_in.echo_width = width_in[TIMEOUT_W-1:0];

      case (range_mode)
         MODE_PRESENCE: begin
            ctl_in.sel     = presence_level ? SEL_ZERO : SEL_FAR;
            ctl_in.updated = 1'b1;
            phase_in       = '0;
         end
         MODE_TOF: begin
            ctl_in.sel     = (!tof_present || tof_mm == TOF_OUT_OF_RANGE) ? SEL_FAR : SEL_TOF;
            ctl_in.updated = 1'b1;
            phase_in       = '0;
         end
         default: begin
            // harvest a finished echo
            if (pending_ff && done_in) begin
               done_in        = 1'b0;
               pending_in     = 1'b0;
               ctl_in.updated = 1'b1;
               if (width_in == '0 || width_in > TICK_W'(timeout_us)) begin
                  ctl_in.sel = SEL_FAR;
               end else begin
                  ctl_in.sel = SEL_ECHO;
               end
            end
            // new period; an unanswered measurement reads far
            if (period_due) begin
               if (pending_in) begin
                  ctl_in.sel     = SEL_FAR;
                  ctl_in.updated = 1'b1;
               end
               last_trig_in = tick_ff;
               done_in      = 1'b0;
               pending_in   = 1'b1;
               phase_in     = PHASE_FIRST;
            end
            if (phase_in != '0) begin
               ctl_in.trig = phase_in > PHASE_LOW;
               if (phase_in >= PHASE_LAST) begin
                  phase_in = '0;
               end else begin
                  phase_in = phase_in + PHASE_W'(1);
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= '0;
         start_ff     <= '0;
         width_ff     <= '0;
         done_ff      <= 1'b0;
         pending_ff   <= 1'b0;
         prev_ff      <= 1'b0;
         last_trig_ff <= '0;
         phase_ff     <= '0;
      end else if (step) begin
         tick_ff      <= tick_in;
         start_ff     <= start_in;
         width_ff     <= width_in;
         done_ff      <= done_in;
         pending_ff   <= pending_in;
         prev_ff      <= prev_in;
         last_trig_ff <= last_trig_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ctl_ff <= ctl_in;
      end
   end

   assign ctl_out = ctl_ff;

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PHASE_LAST)
      else $error("trigger phase beyond pulse end");

   a_side_modes: assert property (@(posedge clock) disable iff (reset)
      step && (range_mode == MODE_PRESENCE || range_mode == MODE_TOF)
      |=> phase_ff == '0 && ctl_ff.updated && !ctl_ff.trig)
      else $error("presence or tof mode left pulse running or skipped update");

   a_period_start: assert property (@(posedge clock) disable iff (reset)
      step && range_mode != MODE_PRESENCE && range_mode != MODE_TOF && period_due
      |=> pending_ff && phase_ff == PHASE_FIRST + PHASE_W'(1)
          && last_trig_ff == $past(tick_ff))
      else $error("period start did not arm measurement");

endmodule

>>> hw/rtl/urm_scale.sv
// distance scaling pipeline and held distance register
module urm_scale import urm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  scale_en_type      en,
   input  ctl_type           ctl,
   output logic              trigger_level,
   output logic [DIST_W-1:0] distance_q4,
   output logic              distance_updated
);

   // numerator stage
   dist_sel_type          sel2_ff;
   logic                  trig2_ff, upd2_ff;
   logic [ECHO_NUM_W-1:0] num_echo_ff, num_echo_in;
   logic [TOF_NUM_W-1:0]  num_tof_ff, num_tof_in;

   // quotient stage
   dist_sel_type          sel3_ff;
   logic                  trig3_ff, upd3_ff;
   logic [ECHO_Q_W-1:0]   q_echo_ff, q_echo_in;
   logic [DIST_W-1:0]     q_tof_ff, q_tof_in;
   logic [ECHO_PROD_W-1:0] prod_echo;
   logic [TOF_PROD_W-1:0]  prod_tof;

   logic [DIST_W-1:0]     held_ff, held_in;

   assign num_echo_in = ECHO_NUM_W'(ctl.echo_width) * ECHO_MUL + ECHO_ADD;
   assign num_tof_in  = {1'b0, ctl.tof_mm, 3'b000} + TOF_ADD;

   // division by constant through reciprocal multiply
   assign prod_echo = ECHO_PROD_W'(num_echo_ff) * ECHO_RECIP;
   assign prod_tof  = TOF_PROD_W'(num_tof_ff) * TOF_RECIP;
   assign q_echo_in = prod_echo[ECHO_RECIP_SHIFT +: ECHO_Q_W];
   assign q_tof_in  = prod_tof[TOF_RECIP_SHIFT +: DIST_W];

   always_ff @(posedge clock) begin
      if (en.load_num) begin
         sel2_ff     <= ctl.sel;
         trig2_ff    <= ctl.trig;
         upd2_ff     <= ctl.updated;
         num_echo_ff <= num_echo_in;
         num_tof_ff  <= num_tof_in;
      end
      if (en.load_quo) begin
         sel3_ff   <= sel2_ff;
         trig3_ff  <= trig2_ff;
         upd3_ff   <= upd2_ff;
         q_echo_ff <= q_echo_in;
         q_tof_ff  <= q_tof_in;
      end
   end

   always_comb begin
      case (sel3_ff)
         SEL_KEEP: held_in = held_ff;
         SEL_FAR:  held_in = FAR_Q;
         SEL_ZERO: held_in = '0;
         SEL_ECHO: held_in = DIST_W'(q_echo_ff);
         SEL_TOF:  held_in = q_tof_ff;
         default:  held_in = held_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= FAR_Q;
      end else if (en.load_held) begin
         held_ff <= held_in;
      end
   end

   assign trigger_level    = trig3_ff;
   assign distance_q4      = held_in;
   assign distance_updated = upd3_ff;

endmodule

>>> test/ultrasonic_range_meter_checker.sv
// checker for the range meter: predicts every tick result and compares each result transfer
`timescale 1ns / 100ps
module ultrasonic_range_meter_checker import urm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   output int unsigned            fail_count,
   output int unsigned            pending_count,
   output int unsigned            update_count,
   output int unsigned            trigger_count,
   output int unsigned            stall_count
);

   typedef struct packed {
      logic              trig;
      logic [DIST_W-1:0] distance;
      logic              updated;
   } reading_type;

   localparam int PULSE_END = TRIG_LOW_TICKS_DEF + TRIG_HIGH_TICKS_DEF;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;
   localparam int PRINT_LIMIT = 30;

   // register copies
   logic [MODE_W-1:0]     mode_q;
   logic [INTERVAL_W-1:0] interval_q;
   logic [TIMEOUT_W-1:0]  timeout_q;

   // tick and echo tracking
   logic [TICK_W-1:0] tick_cnt;
   logic [TICK_W-1:0] rise_stamp;
   logic [TICK_W-1:0] echo_len;
   logic [TICK_W-1:0] period_stamp;
   logic              echo_done;
   logic              echo_armed;
   logic              echo_last;
   logic [3:0]        pulse_pos;
   logic [DIST_W-1:0] held_dist;

   reading_type expected_readings[$];

   function automatic logic [DIST_W-1:0] clip_dist(logic [63:0] v);
      return (v > 64'(DIST_MAX)) ? DIST_MAX : v[DIST_W-1:0];
   endfunction

   // cm * 16 from echo width in microseconds, rounded half up
   function automatic logic [DIST_W-1:0] echo_cm_q4(logic [TICK_W-1:0] w);
      logic [63:0] num;
      num = (64'(w) * 64'd1715) << FRAC_BITS;
      return clip_dist((num + 64'd50000) / 64'd100000);
   endfunction

   function automatic reading_type range_tick(logic echo, logic presence, logic tof_ok,
                                              logic [MM_W-1:0] mm);
      reading_type       r;
      logic [TICK_W-1:0] now;
      now = tick_cnt;
      r   = '0;

      // edges are tracked in every mode
      if (echo && !echo_last) begin
         rise_stamp = now;
      end else if (!echo && echo_last) begin
         echo_len  = now - rise_stamp;
         echo_done = 1'b1;
      end
      echo_last = echo;

      if (mode_q == MODE_PRESENCE) begin
         held_dist = presence ? '0 : FAR_Q;
         r.updated = 1'b1;
         pulse_pos = '0;
      end else if (mode_q == MODE_TOF) begin
         if (!tof_ok || mm == TOF_OUT_OF_RANGE)
            held_dist = FAR_Q;
         else
            held_dist = clip_dist(((64'(mm) << FRAC_BITS) + 64'd5) / 64'd10);
         r.updated = 1'b1;
         pulse_pos = '0;
      end else begin
         // harvest a finished echo
         if (echo_armed && echo_done) begin
            echo_done  = 1'b0;
            echo_armed = 1'b0;
            if (echo_len == '0 || echo_len > TICK_W'(timeout_q))
               held_dist = FAR_Q;
            else
               held_dist = echo_cm_q4(echo_len);
            r.updated = 1'b1;
         end
         // new period; an unanswered one reads far
         if (now - period_stamp >= TICK_W'(interval_q)) begin
            if (echo_armed) begin
               held_dist  = FAR_Q;
               echo_armed = 1'b0;
               r.updated  = 1'b1;
            end
            period_stamp = now;
            echo_done    = 1'b0;
            echo_armed   = 1'b1;
            pulse_pos    = 4'd1;
         end
         if (pulse_pos != '0) begin
            r.trig = (pulse_pos > TRIG_LOW_TICKS_DEF);
            if (pulse_pos >= PULSE_END)
               pulse_pos = '0;
            else
               pulse_pos = pulse_pos + 4'd1;
         end
      end

      tick_cnt   = now + 1'b1;
      r.distance = held_dist;
      return r;
   endfunction

   task automatic flag_error(string what, longint unsigned want, longint unsigned got);
      fail_count++;
      if (fail_count <= PRINT_LIMIT)
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
   endtask

   always @(posedge clock) begin
      reading_type want;
      reading_type got;
      if (reset) begin
         mode_q       = MODE_ECHO;
         interval_q   = INTERVAL_RESET;
         timeout_q    = TIMEOUT_RESET;
         tick_cnt     = '0;
         rise_stamp   = '0;
         echo_len     = '0;
         period_stamp = '0;
         echo_done    = 1'b0;
         echo_armed   = 1'b0;
         echo_last    = 1'b0;
         pulse_pos    = '0;
         held_dist    = FAR_Q;
         expected_readings.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_RANGE_MODE:  mode_q     = csr_wdata[MODE_W-1:0];
               CSR_INTERVAL_US: interval_q = csr_wdata[INTERVAL_W-1:0];
               CSR_TIMEOUT_US:  timeout_q  = csr_wdata[TIMEOUT_W-1:0];
               default: ;
            endcase
         end

         if (req_tvalid && req_tready)
            expected_readings.push_back(range_tick(req_tdata[0], req_tdata[1], req_tdata[2],
                                                   req_tdata[3 +: MM_W]));
         if (req_tvalid && !req_tready)
            stall_count++;

         if (rsp_tvalid && rsp_tready) begin
            got.trig     = rsp_tdata[0];
            got.distance = rsp_tdata[1 +: DIST_W];
            got.updated  = rsp_tdata[1 + DIST_W];
            update_count  += got.updated;
            trigger_count += got.trig;
            if (expected_readings.size() == 0) begin
               fail_count++;
               if (fail_count <= PRINT_LIMIT)
                  $display("%0t: unexpected result, actual trigger %0d distance %0d updated %0d",
                           $time, got.trig, got.distance, got.updated);
            end else begin
               want = expected_readings.pop_front();
               if (got.trig != want.trig)
                  flag_error("trigger_level", want.trig, got.trig);
               if (got.distance != want.distance)
                  flag_error("distance_q4", want.distance, got.distance);
               if (got.updated != want.updated)
                  flag_error("distance_updated", want.updated, got.updated);
            end
         end
      end
      pending_count = expected_readings.size();
   end

endmodule

>>> test/ultrasonic_range_meter_tb.sv
// testbench top for the range meter: stimulus, register settings and verdict
`timescale 1ns / 100ps
module ultrasonic_range_meter_tb;
   import urm_pkg::*;

   // mode code 3 has no name in the package; the block runs echo timing for it
   localparam logic [MODE_W-1:0]      MODE_SPARE   = 2'd3;
   // unused register index, writes to it must change nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE    = 2'd3;
   localparam int                     HOLD_CYCLES  = 80;
   localparam int                     SETTLE_TICKS = 20;
   localparam int                     RANDOM_TICKS = 1000;
   localparam int                     CYCLE_LIMIT  = 500000;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned update_count;
   int unsigned trigger_count;
   int unsigned stall_count;

   // stimulus state
   logic                  sender_eager = 1'b0;
   logic                  rsp_eager    = 1'b0;
   logic                  hold_request = 1'b0;
   logic [INTERVAL_W-1:0] cur_interval;
   logic [TIMEOUT_W-1:0]  cur_timeout;
   int unsigned           sent_ticks   = 0;
   int unsigned           setting_count = 0;
   int unsigned           cycle_count  = 0;

   ultrasonic_range_meter dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ultrasonic_range_meter_checker watch (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .update_count  (update_count),
      .trigger_count (trigger_count),
      .stall_count   (stall_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly no gap, some short ones, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(5, 30);
   endfunction

   // register write, one cycle of csr_we per register
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   // stop offering and wait until every expected result has come back, then let
   // the pipeline run dry
   task automatic settle();
      req_tvalid = 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   // one tick item; waits for its transfer
   task automatic send_tick(input logic echo, input logic presence, input logic tof_ok,
                            input logic [MM_W-1:0] mm);
      int gap;
      gap = sender_eager ? 0 : pick_gap();
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = REQ_TDATA_W'({mm, tof_ok, presence, echo});
      req_tvalid = 1'b1;
      do
         @(posedge clock);
      while (!req_tready);
      @(negedge clock);
      sent_ticks++;
   endtask

   // write all three registers; mode and timeout carry junk above their width
   task automatic apply_setting(input logic [MODE_W-1:0] mode, input logic [INTERVAL_W-1:0] ivl,
                                input logic [TIMEOUT_W-1:0] tmo);
      cur_interval = ivl;
      cur_timeout  = tmo;
      write_reg(CSR_RANGE_MODE, {(CSR_DATA_W - MODE_W)'($urandom), mode});
      write_reg(CSR_INTERVAL_US, ivl);
      write_reg(CSR_TIMEOUT_US, {(CSR_DATA_W - TIMEOUT_W)'($urandom), tmo});
      setting_count++;
   endtask

   // receiver: random gaps, sometimes eager, and long hold-offs on request
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (hold_request) begin
            // long stall so the block fills up and pushes back on req
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            gap = rsp_eager ? 0 : pick_gap();
            if (gap != 0) begin
               rsp_tready = 1'b0;
               repeat (gap) @(negedge clock);
            end
            rsp_tready = 1'b1;
            @(negedge clock);
            if ($urandom_range(0, 199) == 0)
               rsp_eager = ~rsp_eager;
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock) cycle_count++;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      logic            echo_lvl;
      int unsigned     echo_run;
      int unsigned     hi_max;
      int unsigned     lo_max;
      int unsigned     random_sent;
      int unsigned     phase;
      int unsigned     phase_len;
      logic [MM_W-1:0] mm;
      logic [MODE_W-1:0]     mode;
      logic [INTERVAL_W-1:0] ivl;
      logic [TIMEOUT_W-1:0]  tmo;

      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // ---- directed part ----

      // time of flight: zero, rounding, top of range, out of range, sensor absent
      apply_setting(MODE_TOF, INTERVAL_RESET, TIMEOUT_RESET);
      send_tick(1'b0, 1'b0, 1'b1, 16'd0);
      send_tick(1'b0, 1'b0, 1'b1, 16'd1);
      send_tick(1'b0, 1'b0, 1'b1, 16'd5);
      send_tick(1'b0, 1'b0, 1'b1, 16'd15);
      send_tick(1'b0, 1'b0, 1'b1, 16'hFFFE);
      send_tick(1'b0, 1'b0, 1'b1, TOF_OUT_OF_RANGE);
      send_tick(1'b0, 1'b1, 1'b0, 16'd1234);
      send_tick(1'b1, 1'b1, 1'b1, 16'hAAAA);
      send_tick(1'b0, 1'b0, 1'b1, 16'h5555);
      settle();

      // presence: object, none, object
      apply_setting(MODE_PRESENCE, INTERVAL_RESET, TIMEOUT_RESET);
      send_tick(1'b0, 1'b1, 1'b0, 16'hFFFF);
      send_tick(1'b1, 1'b0, 1'b0, 16'h0000);
      send_tick(1'b0, 1'b1, 1'b1, 16'h0F0F);
      settle();

      // spare mode as echo timing with the shortest period and timeout: a period
      // starts every tick, so pulses restart, unanswered periods read far, and a
      // harvest lands in the same tick as a start; width one fits, width two is too long
      apply_setting(MODE_SPARE, INTERVAL_W'(1), TIMEOUT_W'(1));
      send_tick(1'b0, 1'b0, 1'b1, 16'd0);
      send_tick(1'b1, 1'b0, 1'b1, 16'd0);
      send_tick(1'b0, 1'b0, 1'b1, 16'd0);
      send_tick(1'b1, 1'b0, 1'b1, 16'd0);
      send_tick(1'b1, 1'b0, 1'b1, 16'd0);
      send_tick(1'b0, 1'b0, 1'b1, 16'd0);
      send_tick(1'b0, 1'b0, 1'b1, 16'd0);
      settle();

      // longest period and timeout: no trigger within reach, echo edges still tracked
      apply_setting(MODE_ECHO, '1, '1);
      write_reg(CSR_SPARE, CSR_DATA_W'($urandom));
      send_tick(1'b1, 1'b1, 1'b1, 16'd7);
      send_tick(1'b0, 1'b0, 1'b0, 16'd7);
      send_tick(1'b1, 1'b0, 1'b1, 16'd7);
      settle();

      // ---- random part: one register setting per phase ----
      echo_lvl    = 1'b0;
      echo_run    = 0;
      random_sent = 0;
      phase       = 0;
      while (random_sent < RANDOM_TICKS) begin
         case ($urandom_range(0, 19))
            0, 1, 2:    mode = MODE_PRESENCE;
            3, 4, 5:    mode = MODE_TOF;
            6, 7:       mode = MODE_SPARE;
            default:    mode = MODE_ECHO;
         endcase
         case ($urandom_range(0, 9))
            0:       ivl = INTERVAL_W'(1);
            1:       ivl = '1;
            default: ivl = INTERVAL_W'($urandom_range(15, 250));
         endcase
         case ($urandom_range(0, 9))
            0:       tmo = TIMEOUT_W'(1);
            1:       tmo = '1;
            default: tmo = TIMEOUT_W'($urandom_range(1, 120));
         endcase
         apply_setting(mode, ivl, tmo);
         if ($urandom_range(0, 3) == 0)
            write_reg(CSR_SPARE, CSR_DATA_W'($urandom));

         // two phases run with the receiver held off and the sender flat out
         if (phase == 2 || phase == 6) begin
            sender_eager = 1'b1;
            hold_request = 1'b1;
         end else begin
            sender_eager = ($urandom_range(0, 4) == 0);
         end

         // echo runs scaled to the period and timeout so edges land on both sides
         hi_max    = (cur_timeout > 297) ? 300 : cur_timeout + 3;
         lo_max    = (cur_interval > 300) ? 300 : cur_interval;
         phase_len = $urandom_range(60, 140);
         repeat (phase_len) begin
            if (echo_run == 0) begin
               echo_lvl = ~echo_lvl;
               echo_run = echo_lvl ? $urandom_range(1, hi_max) : $urandom_range(1, lo_max);
               if ($urandom_range(0, 7) == 0)
                  echo_run = 1;
            end
            echo_run--;
            case ($urandom_range(0, 7))
               0:       mm = '0;
               1:       mm = TOF_OUT_OF_RANGE;
               2:       mm = 16'hFFFE;
               3:       mm = MM_W'($urandom_range(0, 200));
               default: mm = MM_W'($urandom);
            endcase
            send_tick(echo_lvl, 1'($urandom), ($urandom_range(0, 5) != 0), mm);
            random_sent++;
         end
         settle();
         phase++;
      end
      sender_eager = 1'b0;

      $display("ran %0d ticks over %0d register settings, all range modes and period extremes",
               sent_ticks, setting_count);
      $display("saw %0d distance updates, %0d trigger-high ticks, %0d cycles of input stall",
               update_count, trigger_count, stall_count);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
